>>> rtl/pdmq_pkg.sv
`timescale 1ns / 1ps

package pdmq_pkg;

    // Default sizing of the kept-magnitude store
    localparam int MAX_DIMS_DEF = 128;
    localparam int MAX_KEEP_DEF = 16;

    // Field widths
    localparam int DIM_W   = 7;
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 31;
    localparam int STAT_W  = 2;

    localparam int IN_TDATA_W  = ((DIM_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STAT_W + MAG_W + 7) / 8) * 8;

    // Configuration registers
    localparam int NUM_KEEP_W = 5;
    localparam int MAX_DP_W   = 24;
    localparam int DIMS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [NUM_KEEP_W-1:0] NUM_KEEP_RST = 5'd1;
    localparam logic [MAX_DP_W-1:0]   MAX_DP_RST   = 24'hFF_FFFF;
    localparam logic [DIMS_W-1:0]     DIMS_RST     = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_KEEP = 2'd0,
        CFG_MAX_DP   = 2'd1,
        CFG_DIMS     = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_QUERY  = 1'b1
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_DIM = 2'd1,
        STAT_LIMIT   = 2'd2
    } stat_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take the input beat
        logic cnt_rd;     // read the dimension's count
        logic held_calc;  // work out held entries, read the lowest
        logic res_cap;    // capture the queried magnitude
        logic walk;       // one step of the insertion walk
        logic fin;        // place the new magnitude, write the count
        logic out_load;   // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_query;
        logic err;
        logic held_zero;
        logic walk_done;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> rtl/pdmq_ram.sv
`timescale 1ns / 1ps

module pdmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pdmq_ctrl.sv
`timescale 1ns / 1ps

module pdmq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pdmq_pkg::dp_stat_t    stat,
    output pdmq_pkg::ctrl_cmd_t   cmd
);

    import pdmq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_CNT_RD   = 7'b000_0010,
        ST_CNT_DATA = 7'b000_0100,
        ST_QDATA    = 7'b000_1000,
        ST_WALK     = 7'b001_0000,
        ST_FIN      = 7'b010_0000,
        ST_OUT      = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD:
            begin
                if (stat.err)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = ST_CNT_DATA;
                end
            end
            ST_CNT_DATA:
            begin
                cmd.held_calc = 1'b1;
                if (stat.is_query)
                begin
                    state_next = stat.held_zero ? ST_OUT : ST_QDATA;
                end
                else
                begin
                    state_next = stat.held_zero ? ST_FIN : ST_WALK;
                end
            end
            ST_QDATA:
            begin
                cmd.res_cap = 1'b1;
                state_next  = ST_OUT;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> rtl/pdmq_dp.sv
`timescale 1ns / 1ps

module pdmq_dp #(
    parameter int MAX_DIMS = pdmq_pkg::MAX_DIMS_DEF,
    parameter int MAX_KEEP = pdmq_pkg::MAX_KEEP_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pdmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdmq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [pdmq_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  pdmq_pkg::ctrl_cmd_t                cmd,
    output pdmq_pkg::dp_stat_t                 stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdmq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import pdmq_pkg::*;

    localparam int DIM_AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W     = $clog2(MAX_KEEP + 1);
    localparam int MAG_DEPTH = MAX_DIMS * MAX_KEEP;
    localparam int MAG_AW    = (MAG_DEPTH > 1) ? $clog2(MAG_DEPTH) : 1;

    // Configuration
    logic [NUM_KEEP_W-1:0] num_keep_reg;
    logic [MAX_DP_W-1:0]   max_dp_reg;
    logic [DIMS_W-1:0]     dims_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_keep_reg <= NUM_KEEP_RST;
            max_dp_reg   <= MAX_DP_RST;
            dims_reg     <= DIMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_KEEP: num_keep_reg <= cfg_data[NUM_KEEP_W-1:0];
                CFG_MAX_DP:   max_dp_reg   <= cfg_data[MAX_DP_W-1:0];
                CFG_DIMS:     dims_reg     <= cfg_data[DIMS_W-1:0];
                default:      ;
            endcase
        end
    end

    logic [CNT_W-1:0] keep_eff;

    always_comb
    begin
        priority if (num_keep_reg == '0)
        begin
            keep_eff = CNT_W'(1);
        end
        else if (32'(num_keep_reg) > MAX_KEEP)
        begin
            keep_eff = CNT_W'(MAX_KEEP);
        end
        else
        begin
            keep_eff = CNT_W'(num_keep_reg);
        end
    end

    // Input beat and item status
    logic [DIM_W-1:0] in_dim;
    logic [MAG_W-1:0] in_mag;
    logic             dim_ok;
    logic             limit_hit;
    stat_t            in_stat;

    assign in_dim    = s_tdata[DIM_W-1:0];
    assign in_mag    = s_tdata[DIM_W+MAG_W-1:DIM_W];   // sign bit dropped
    assign dim_ok    = (32'(in_dim) < 32'(dims_reg)) && (32'(in_dim) < MAX_DIMS);

    logic [MAX_DP_W-1:0] dp_reg;
    assign limit_hit = (dp_reg >= max_dp_reg);

    always_comb
    begin
        priority if (!dim_ok)
        begin
            in_stat = STAT_BAD_DIM;
        end
        else if ((s_tuser == KIND_SAMPLE) && limit_hit)
        begin
            in_stat = STAT_LIMIT;
        end
        else
        begin
            in_stat = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg <= '0;
        end
        else if (cmd.load && (s_tuser == KIND_SAMPLE) && (in_stat == STAT_OK) && s_tlast)
        begin
            dp_reg <= dp_reg + MAX_DP_W'(1);
        end
    end

    logic             kind_reg;
    logic [DIM_W-1:0] dim_reg;
    logic [MAG_W-1:0] mag_reg;
    stat_t            stat_reg;
    logic [MAG_W-1:0] res_reg;
    logic [MAG_W-1:0] mag_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= STAT_OK;
        end
        else if (cmd.load)
        begin
            stat_reg <= in_stat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= s_tuser;
            dim_reg  <= in_dim;
            mag_reg  <= in_mag;
            res_reg  <= '0;
        end
        else if (cmd.res_cap)
        begin
            res_reg <= mag_q;
        end
    end

    // Count store with per-dimension valid bits
    logic [DIM_AW-1:0]   dim_addr;
    logic [MAX_DIMS-1:0] valid_reg;
    logic [CNT_W-1:0]    cnt_q;
    logic [CNT_W-1:0]    cnt_raw;
    logic [CNT_W-1:0]    held;
    logic [CNT_W-1:0]    held_reg;
    logic [CNT_W-1:0]    cnt_new;

    assign dim_addr = DIM_AW'(dim_reg);
    assign cnt_raw  = valid_reg[dim_addr] ? cnt_q : '0;
    assign held     = (cnt_raw < keep_eff) ? cnt_raw : keep_eff;
    assign cnt_new  = (held_reg < keep_eff) ? (held_reg + CNT_W'(1)) : keep_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.fin)
        begin
            valid_reg[dim_addr] <= 1'b1;
        end
    end

    pdmq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_DIMS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.fin),
        .waddr (dim_addr),
        .wdata (cnt_new),
        .re    (cmd.cnt_rd),
        .raddr (dim_addr),
        .rdata (cnt_q)
    );

    // Insertion walk: from the smallest held entry upward, shift smaller
    // entries down by one until one at least as large is met.
    logic [CNT_W-1:0]  j_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  j_plus;
    logic [CNT_W-1:0]  j_minus;
    logic [CNT_W-1:0]  held_m1;
    logic              walk_stop;
    logic [MAG_AW-1:0] row_base;

    assign j_plus    = j_reg + CNT_W'(1);
    assign j_minus   = j_reg - CNT_W'(1);
    assign held_m1   = held - CNT_W'(1);
    assign walk_stop = (mag_q >= mag_reg);
    assign row_base  = MAG_AW'(32'(dim_addr) * MAX_KEEP);

    always_ff @(posedge clk)
    begin
        if (cmd.held_calc)
        begin
            held_reg <= held;
            j_reg    <= held_m1;
            pos_reg  <= '0;
        end
        else if (cmd.walk)
        begin
            j_reg <= j_minus;
            if (walk_stop)
            begin
                pos_reg <= j_plus;
            end
            else if (j_reg == '0)
            begin
                pos_reg <= '0;
            end
        end
    end

    logic              mag_re;
    logic [MAG_AW-1:0] mag_raddr;
    logic              walk_we;
    logic              fin_we;
    logic              mag_we;
    logic [MAG_AW-1:0] mag_waddr;
    logic [MAG_W-1:0]  mag_wdata;

    assign mag_re    = (cmd.held_calc && (held != '0))
                    || (cmd.walk && !walk_stop && (j_reg != '0));
    assign mag_raddr = cmd.held_calc ? (row_base + MAG_AW'(held_m1))
                                     : (row_base + MAG_AW'(j_minus));
    assign walk_we   = cmd.walk && !walk_stop && (j_plus < keep_eff);
    assign fin_we    = cmd.fin && (pos_reg < keep_eff);
    assign mag_we    = walk_we || fin_we;
    assign mag_waddr = cmd.fin ? (row_base + MAG_AW'(pos_reg))
                               : (row_base + MAG_AW'(j_plus));
    assign mag_wdata = cmd.fin ? mag_reg : mag_q;

    pdmq_ram #(
        .WIDTH (MAG_W),
        .DEPTH (MAG_DEPTH)
    ) u_mag_ram (
        .clk   (clk),
        .we    (mag_we),
        .waddr (mag_waddr),
        .wdata (mag_wdata),
        .re    (mag_re),
        .raddr (mag_raddr),
        .rdata (mag_q)
    );

    // Output register
    logic                   out_valid_reg;
    logic [STAT_W-1:0]      out_stat_reg;
    logic [MAG_W-1:0]       out_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_stat_reg <= stat_reg;
            out_mag_reg  <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - STAT_W - MAG_W)'(0), out_mag_reg, out_stat_reg};

    assign stat.is_query  = (kind_reg == KIND_QUERY);
    assign stat.err       = (stat_reg != STAT_OK);
    assign stat.held_zero = (held == '0);
    assign stat.walk_done = walk_stop || (j_reg == '0);
    assign stat.out_busy  = out_valid_reg && !m_tready;

endmodule

>>> rtl/per_dim_magnitude_quantile_top.sv
`timescale 1ns / 1ps

// Per-dimension magnitude tracker. Each input beat on the s_ side is either a
// sample element (tuser 0) whose magnitude joins that dimension's sorted list
// of the num_keep largest, or a query (tuser 1) that returns the smallest kept
// magnitude of one dimension. Every input beat gives exactly one result beat
// on the m_ side: a status code and, for a good query, the magnitude.
// Items are handled one at a time; s_tready drops for the whole of an item.
// An item's result can first be taken at the same edge as the next input
// beat. A refused item goes straight to the output, a query with nothing held
// skips the magnitude read, and a sample walks up to MAX_KEEP kept entries.
// The walk reads one kept entry per cycle from the magnitude RAM and writes
// it one place down.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item is still taken and worked on, waiting at its end until
// the register frees up.
// Reset clears the kept counts (per-dimension valid bits), the datapoint
// counter and the output valid, and loads the configuration defaults. The
// magnitude RAM is not cleared: only entries below a dimension's count are
// ever read. Write configuration only while no item is in flight.

module per_dim_magnitude_quantile_top #(
    parameter int MAX_DIMS = pdmq_pkg::MAX_DIMS_DEF,
    parameter int MAX_KEEP = pdmq_pkg::MAX_KEEP_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port: 0 num_keep, 1 max_datapoints, 2 dims_in_use
    input  logic                               cfg_we,
    input  logic [pdmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdmq_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pdmq_pkg::IN_TDATA_W-1:0]    s_tdata,  // dim_index[6:0], value_bits[38:7]
    input  logic                               s_tuser,  // kind
    input  logic                               s_tlast,  // last_element
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pdmq_pkg::OUT_TDATA_W-1:0]   m_tdata   // status[1:0], magnitude_bits[32:2]
);

    import pdmq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencing: accept, count read, walk, place, hand over
    pdmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stores, compares and the output register
    pdmq_dp #(
        .MAX_DIMS (MAX_DIMS),
        .MAX_KEEP (MAX_KEEP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/pdmq_checker.sv
`timescale 1ns / 1ps

module pdmq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pdmq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import pdmq_pkg::*;

    // No result beat once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // One item at a time: input closes after each beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after a beat");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Status is a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STAT_W-1:0] == STAT_OK
                   || m_tdata[STAT_W-1:0] == STAT_BAD_DIM
                   || m_tdata[STAT_W-1:0] == STAT_LIMIT))
        else $error("undefined status code");

    // Refused items carry no magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[STAT_W-1:0] != STAT_OK))
            |-> (m_tdata[STAT_W+MAG_W-1:STAT_W] == '0))
        else $error("magnitude on a refused item");

endmodule

bind per_dim_magnitude_quantile_top pdmq_checker u_pdmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pdmq_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_FROM    = 380;     // random items after which nobody idles
    localparam int TAIL_CYCLES  = 40;      // longest item latency plus margin

    // IEEE single patterns used as special values
    localparam logic [VALUE_W-1:0] F_ZERO     = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] F_NEG_ZERO = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] F_ONE      = 32'h3F80_0000;
    localparam logic [VALUE_W-1:0] F_NEG_TWO  = 32'hC000_0000;
    localparam logic [VALUE_W-1:0] F_THREE    = 32'h4040_0000;
    localparam logic [VALUE_W-1:0] F_FIVE     = 32'h40A0_0000;
    localparam logic [VALUE_W-1:0] F_INF      = 32'h7F80_0000;
    localparam logic [VALUE_W-1:0] F_QNAN     = 32'h7FC0_0000;
    localparam logic [VALUE_W-1:0] F_ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        stat_t            status;
        logic [MAG_W-1:0] mag;
    } answer_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // dim_index[6:0], value_bits[38:7]
    logic                   s_tuser = 1'b0;  // kind
    logic                   s_tlast = 1'b0;  // last_element
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // status[1:0], magnitude_bits[32:2]

    per_dim_magnitude_quantile_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Own copy of the tracker: sorted top lists, counts, datapoint counter
    logic [MAG_W-1:0]    kept_mag [MAX_DIMS_DEF][MAX_KEEP_DEF];
    int unsigned         kept_cnt [MAX_DIMS_DEF];
    logic [MAX_DP_W-1:0] dp_taken = '0;
    logic [NUM_KEEP_W-1:0] keep_reg  = NUM_KEEP_RST;
    logic [MAX_DP_W-1:0]   maxdp_reg = MAX_DP_RST;
    logic [DIMS_W-1:0]     dims_reg  = DIMS_RST;

    answer_t     awaited_answers [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned directed_items = 0;
    int unsigned answers_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned n_ok = 0, n_bad_dim = 0, n_limit = 0, n_queries = 0;
    int unsigned rx_stall = 0;
    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;
    logic [MAG_W-1:0] tie_pool [4];

    initial begin
        forever #2 clk = ~clk;
    end

    // Hard stop if the block hangs
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d answers still awaited",
                     $time, awaited_answers.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tracker prediction
    // ---------------------------------------------------------------

    // num_keep 0 acts as 1, anything above MAX_KEEP saturates
    function automatic int unsigned keep_limit();
        if (keep_reg == 0)
            return 1;
        if (keep_reg > MAX_KEEP_DEF)
            return MAX_KEEP_DEF;
        return keep_reg;
    endfunction

    function automatic int unsigned dims_limit();
        if (dims_reg > MAX_DIMS_DEF)
            return MAX_DIMS_DEF;
        return dims_reg;
    endfunction

    // a list longer than the current keep count is seen as its k largest
    function automatic int unsigned held_count(input int unsigned d);
        int unsigned k;
        k = keep_limit();
        return (kept_cnt[d] < k) ? kept_cnt[d] : k;
    endfunction

    function automatic void insert_magnitude(input int unsigned d, input logic [MAG_W-1:0] m);
        int unsigned k, h, pos, i;
        k   = keep_limit();
        h   = held_count(d);
        pos = 0;
        if (h >= k) begin
            // full list: only a strictly larger magnitude displaces the smallest
            if (m <= kept_mag[d][k-1]) begin
                kept_cnt[d] = k;
                return;
            end
            h = k - 1;
        end
        // equal magnitudes go behind the ones already held
        while (pos < h && kept_mag[d][pos] >= m)
            pos++;
        for (i = h; i > pos; i--)
            kept_mag[d][i] = kept_mag[d][i-1];
        kept_mag[d][pos] = m;
        kept_cnt[d] = h + 1;
    endfunction

    function automatic answer_t predict_answer(input kind_t kind, input logic [DIM_W-1:0] dim,
                                               input logic [VALUE_W-1:0] value, input logic last);
        answer_t     a;
        int unsigned h;
        a.status = STAT_OK;
        a.mag    = '0;
        if (dim >= dims_limit()) begin
            // bad dimension wins over the limit check, and changes nothing
            a.status = STAT_BAD_DIM;
        end else if (kind == KIND_QUERY) begin
            h = held_count(dim);
            if (h > 0)
                a.mag = kept_mag[dim][h-1];
        end else if (dp_taken >= maxdp_reg) begin
            a.status = STAT_LIMIT;
        end else begin
            insert_magnitude(dim, value[MAG_W-1:0]);
            if (last)
                dp_taken = dp_taken + 1'b1;
        end
        return a;
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stalls and the check of every answer beat
    // ---------------------------------------------------------------
    always @(posedge clk) begin : check_answers
        answer_t          want;
        logic [STAT_W-1:0] got_status;
        logic [MAG_W-1:0]  got_mag;
        got_status = m_tdata[STAT_W-1:0];
        got_mag    = m_tdata[STAT_W+MAG_W-1:STAT_W];
        if (rst_n && m_tvalid && m_tready) begin
            answers_seen++;
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d magnitude %h",
                         $time, got_status, got_mag);
                mismatches++;
            end else begin
                want = awaited_answers.pop_front();
                if (got_status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got_status);
                    mismatches++;
                end
                if (got_mag != want.mag) begin
                    $display("%0t: magnitude expected %h actual %h",
                             $time, want.mag, got_mag);
                    mismatches++;
                end
            end
        end
        // stall in bursts when enabled, the length drawn at random
        if (rx_stall > 0)
            rx_stall--;
        else if (rx_idle_en && $urandom_range(0, 99) < 12)
            rx_stall = $urandom_range(1, 12);
        m_tready <= (rx_stall == 0);
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Present one beat, hold it until taken, then record the predicted answer.
    // Valid is left high so back-to-back beats need no second assignment.
    task automatic send_item(input kind_t kind, input logic [DIM_W-1:0] dim,
                             input logic [VALUE_W-1:0] value, input logic last);
        answer_t a;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({value, dim});
        s_tuser  <= kind;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        a = predict_answer(kind, dim, value, last);
        awaited_answers.insert(awaited_answers.size(), a);
        items_sent++;
        if (kind == KIND_QUERY)
            n_queries++;
        case (a.status)
            STAT_OK:      n_ok++;
            STAT_BAD_DIM: n_bad_dim++;
            default:      n_limit++;
        endcase
        if (tx_idle_en && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and hold off until every awaited answer has come back
    task automatic hold_until_answered();
        s_tvalid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Block is idle once everything is answered; write, then mirror in the copy
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        hold_until_answered();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_NUM_KEEP: keep_reg  = value[NUM_KEEP_W-1:0];
            CFG_MAX_DP:   maxdp_reg = value[MAX_DP_W-1:0];
            default:      dims_reg  = value[DIMS_W-1:0];
        endcase
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] draw_value();
        int unsigned pick;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            v = $urandom();
        end else if (pick < 75) begin
            // repeated magnitudes with either sign, for ties
            v = {1'($urandom_range(0, 1)), tie_pool[$urandom_range(0, 3)]};
        end else begin
            case ($urandom_range(0, 5))
                0:       v = F_ZERO;
                1:       v = F_NEG_ZERO;
                2:       v = F_INF;
                3:       v = F_QNAN;
                4:       v = F_ONE;
                default: v = F_ALL_ONES;
            endcase
        end
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Defaults after reset: keep 1, all 128 dimensions, no limit in reach
    task automatic test_defaults();
        send_item(KIND_QUERY,  7'd3,   F_ALL_ONES, 1'b1);   // empty list, fields ignored
        send_item(KIND_SAMPLE, 7'd0,   F_ONE,      1'b0);
        send_item(KIND_SAMPLE, 7'd0,   F_NEG_TWO,  1'b0);   // sign dropped
        send_item(KIND_SAMPLE, 7'd127, F_ALL_ONES, 1'b1);   // NaN sorts above all
        send_item(KIND_QUERY,  7'd0,   F_ZERO,     1'b0);
        send_item(KIND_QUERY,  7'd127, F_ZERO,     1'b0);
        send_item(KIND_SAMPLE, 7'd1,   F_NEG_ZERO, 1'b1);
        send_item(KIND_QUERY,  7'd1,   F_ZERO,     1'b0);
    endtask

    // Keep count: ties, out-of-range values, lowering it mid-stream
    task automatic test_keep_count();
        write_reg(CFG_NUM_KEEP, 24'd3);
        send_item(KIND_SAMPLE, 7'd2, F_FIVE,  1'b0);
        send_item(KIND_SAMPLE, 7'd2, F_ONE,   1'b0);
        send_item(KIND_SAMPLE, 7'd2, F_FIVE,  1'b0);
        send_item(KIND_SAMPLE, 7'd2, F_THREE, 1'b1);
        send_item(KIND_QUERY,  7'd2, F_ZERO,  1'b0);
        write_reg(CFG_NUM_KEEP, 24'd0);                      // acts as 1
        send_item(KIND_QUERY,  7'd2, F_ZERO,  1'b0);
        write_reg(CFG_NUM_KEEP, 24'd31);                     // saturates, list not yet cut
        send_item(KIND_QUERY,  7'd2, F_ZERO,  1'b0);
        write_reg(CFG_NUM_KEEP, 24'd1);
        send_item(KIND_SAMPLE, 7'd2, F_ONE,   1'b0);         // cuts the list to one
        write_reg(CFG_NUM_KEEP, 24'd16);
        send_item(KIND_QUERY,  7'd2, F_ZERO,  1'b0);
    endtask

    // Dimensionality: zero refuses everything, above MAX_DIMS saturates
    task automatic test_dimensions();
        write_reg(CFG_DIMS, 24'd0);
        send_item(KIND_QUERY,  7'd0,   F_ZERO, 1'b0);
        send_item(KIND_SAMPLE, 7'd0,   F_ONE,  1'b0);
        write_reg(CFG_DIMS, 24'd255);
        send_item(KIND_SAMPLE, 7'd127, F_INF,  1'b0);
        write_reg(CFG_DIMS, 24'd4);
        send_item(KIND_SAMPLE, 7'd4,   F_ONE,  1'b0);
        send_item(KIND_QUERY,  7'd3,   F_ZERO, 1'b0);
    endtask

    // Datapoint limit: reached, zero, one more allowed, bad dimension first
    task automatic test_datapoint_limit();
        write_reg(CFG_MAX_DP, 24'(dp_taken));
        send_item(KIND_SAMPLE, 7'd0, F_FIVE, 1'b1);
        send_item(KIND_QUERY,  7'd0, F_ZERO, 1'b0);          // queries ignore the limit
        write_reg(CFG_MAX_DP, 24'd0);
        send_item(KIND_SAMPLE, 7'd1, F_ONE,  1'b0);
        write_reg(CFG_MAX_DP, 24'(dp_taken + 1'b1));
        send_item(KIND_SAMPLE, 7'd1, F_ONE,  1'b1);
        send_item(KIND_SAMPLE, 7'd1, F_ONE,  1'b0);
        send_item(KIND_SAMPLE, 7'd5, F_ONE,  1'b0);          // dims is 4 here
        write_reg(CFG_MAX_DP, MAX_DP_RST);
    endtask

    // Phases of random settings; mostly whole datapoints, then queries and noise
    task automatic test_random_stream();
        int unsigned done, phase_len, phase_done, pick, d, nd;
        logic [DIM_W-1:0] dim;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            // settings change only between phases, with the block drained
            pick = $urandom_range(0, 99);
            if (pick < 10)
                write_reg(CFG_NUM_KEEP, (pick < 4) ? 24'd0 : ((pick < 7) ? 24'd17 : 24'd31));
            else
                write_reg(CFG_NUM_KEEP, 24'($urandom_range(1, MAX_KEEP_DEF)));
            pick = $urandom_range(0, 99);
            if (pick < 70)      write_reg(CFG_DIMS, 24'($urandom_range(1, 8)));
            else if (pick < 78) write_reg(CFG_DIMS, 24'd128);
            else if (pick < 84) write_reg(CFG_DIMS, 24'd255);
            else if (pick < 90) write_reg(CFG_DIMS, 24'd0);
            else                write_reg(CFG_DIMS, 24'($urandom_range(9, 20)));
            pick = $urandom_range(0, 99);
            if (pick < 60)      write_reg(CFG_MAX_DP, MAX_DP_RST);
            else if (pick < 85) write_reg(CFG_MAX_DP, 24'(dp_taken + $urandom_range(0, 8)));
            else if (pick < 92) write_reg(CFG_MAX_DP, 24'd0);
            else                write_reg(CFG_MAX_DP, 24'($urandom_range(1, 24'hFF_FFFF)));

            for (int i = 0; i < 4; i++)
                tie_pool[i] = MAG_W'($urandom());
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            phase_len  = $urandom_range(40, 80);
            phase_done = 0;
            nd = dims_limit();

            while (phase_done < phase_len && done < RANDOM_ITEMS) begin
                // quiet finish: no idling on either side
                if (done >= CALM_FROM) begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 65 && nd > 0 && (nd <= 20 || $urandom_range(0, 3) == 0)) begin
                    // one whole datapoint in dimension order
                    for (d = 0; d < nd; d++)
                        send_item(KIND_SAMPLE, DIM_W'(d), draw_value(), d == nd - 1);
                    phase_done += nd;
                    done       += nd;
                end else if (pick < 85) begin
                    if (nd > 0 && $urandom_range(0, 4) != 0)
                        dim = DIM_W'($urandom_range(0, nd - 1));
                    else
                        dim = DIM_W'($urandom_range(0, MAX_DIMS_DEF - 1));
                    send_item(KIND_QUERY, dim, $urandom(), 1'($urandom_range(0, 1)));
                    phase_done++;
                    done++;
                end else begin
                    // noise: broken datapoints, stray last marks, any index
                    send_item(kind_t'($urandom_range(0, 1)),
                              DIM_W'($urandom_range(0, MAX_DIMS_DEF - 1)),
                              draw_value(), 1'($urandom_range(0, 1)));
                    phase_done++;
                    done++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        for (int d = 0; d < MAX_DIMS_DEF; d++)
            kept_cnt[d] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_defaults();
        test_keep_count();
        test_dimensions();
        test_datapoint_limit();
        directed_items = items_sent;
        test_random_stream();

        // drain, then leave room for any stray late beat
        hold_until_answered();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_answers.size() != 0) begin
            $display("%0t: %0d answers expected but never seen",
                     $time, awaited_answers.size());
            mismatches++;
        end

        $display("Sent %0d beats (%0d directed), %0d answers checked, %0d register writes.",
                 items_sent, directed_items, answers_seen, cfg_writes);
        $display("Outcomes: %0d ok, %0d bad dimension, %0d over limit, %0d queries.",
                 n_ok, n_bad_dim, n_limit, n_queries);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
